/* rtl/core/bbr_pkg.sv */
//------------------------------------------------------------------------------
// bbr_pkg
// Shared types and constants for the BBR ACK path block.
//------------------------------------------------------------------------------
package bbr_pkg;

    localparam int BW_WINDOW_ROUNDS = 10;
    localparam int SLOT_W = $clog2(BW_WINDOW_ROUNDS);

    localparam logic [1:0] CFG_FULL_BW_ROUNDS = 2'd0;
    localparam logic [1:0] CFG_PROBE_RTT_INT  = 2'd1;
    localparam logic [1:0] CFG_MIN_RTT_WINDOW = 2'd2;

    localparam logic [1:0] BW_RES_NONE   = 2'd0;
    localparam logic [1:0] BW_RES_APPLIM = 2'd1;
    localparam logic [1:0] BW_RES_TAKEN  = 2'd2;

    localparam logic [3:0] STALL_SAT = 4'd15;

    typedef struct packed {
        logic step;
        logic refresh;
        logic load_out;
    } bbr_cmd_t;

endpackage

/* rtl/core/bbr_ctrl.sv */
//------------------------------------------------------------------------------
// bbr_ctrl
// Sequencer: accept, update state, refresh max over slots, present result.
//------------------------------------------------------------------------------
module bbr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              out_stall,
    output logic              out_valid,
    output bbr_pkg::bbr_cmd_t cmd
);
    import bbr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_MAX  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_MAX;
                end
            end
            ST_MAX:
            begin
                cmd.refresh = 1'b1;
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/bbr_dp.sv */
//------------------------------------------------------------------------------
// bbr_dp
// Datapath: round counter, bandwidth slots, full-bw detector, RTT filters.
//------------------------------------------------------------------------------
module bbr_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  bbr_pkg::bbr_cmd_t cmd,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [39:0]       cfg_data,
    input  logic [63:0]       now_time,
    input  logic [47:0]       delivered_total,
    input  logic [47:0]       prior_delivered,
    input  logic [39:0]       delivery_rate,
    input  logic              rate_valid,
    input  logic              app_limited,
    input  logic [39:0]       rtt_sample,
    input  logic              rtt_valid,
    output logic              status,
    output logic              round_started,
    output logic [31:0]       round_number,
    output logic [1:0]        bw_sample_result,
    output logic [39:0]       max_bandwidth,
    output logic              bw_plateau_hit,
    output logic              bw_plateau_seen,
    output logic [39:0]       min_rtt,
    output logic              short_rtt_aged,
    output logic              long_rtt_aged
);
    import bbr_pkg::*;

    logic [3:0]  fbr_reg;
    logic [39:0] prt_int_reg, mrw_reg;

    logic [39:0] slots_reg [BW_WINDOW_ROUNDS];
    logic [39:0] bw_max_reg;
    logic [31:0] filter_round_reg, rounds_reg;
    logic        filter_known_reg;
    logic [47:0] mark_reg;
    logic [39:0] base_reg;
    logic [3:0]  stall_reg;
    logic        full_reg;
    logic [39:0] smin_reg, lmin_reg;
    logic [63:0] sstamp_reg, lstamp_reg, last_time_reg;
    logic        sknown_reg, lknown_reg, last_known_reg;
    // rounds and filter_round modulo the window, tracked incrementally
    logic [SLOT_W-1:0] rslot_reg, fslot_reg;

    // per-item flags kept for result
    logic        st_reg, started_reg, fnow_reg, pexp_reg, lexp_reg;
    logic [1:0]  bwres_reg;

    logic        reject, started, rate_ok, admit, fnow, pe, le, s_take, l_take;
    logic        round_wrap;
    logic [31:0] rounds_n, gap;
    logic [39:0] thr_base;
    logic [41:0] thr;
    logic [39:0] slot_val;
    logic [SLOT_W-1:0] cur_slot;
    logic [BW_WINDOW_ROUNDS-1:0] clr;
    logic [3:0]  stall_inc;
    logic [39:0] smin_n;
    logic [63:0] sstamp_n;
    logic [39:0] max_tree;

    assign reject  = last_known_reg && (now_time < last_time_reg);
    assign started = (delivered_total != '0) && (delivered_total >= prior_delivered)
                     && (prior_delivered >= mark_reg);
    assign rounds_n = rounds_reg + {31'd0, started};
    assign rate_ok  = rate_valid && (delivery_rate != '0);
    assign admit    = rate_ok && !(app_limited && (delivery_rate < bw_max_reg));
    assign gap      = rounds_n - filter_round_reg;
    assign round_wrap = (rounds_n < filter_round_reg);
    assign cur_slot = !started ? rslot_reg
                    : (rounds_reg == '1) ? '0
                    : (rslot_reg == SLOT_W'(BW_WINDOW_ROUNDS - 1)) ? '0
                    : rslot_reg + SLOT_W'(1);

    // slot k is (off) rounds past the last aged round; a round counter wrap
    // splits the run into the tail before the wrap and rounds 0..rounds_n
    always_comb
    begin
        logic [SLOT_W:0] off;
        off = '0;
        for (int k = 0; k < BW_WINDOW_ROUNDS; k++)
        begin
            if (SLOT_W'(k) > fslot_reg)
            begin
                off = (SLOT_W+1)'(k) - {1'b0, fslot_reg};
            end
            else
            begin
                off = (SLOT_W+1)'(k + BW_WINDOW_ROUNDS) - {1'b0, fslot_reg};
            end
            clr[k] = filter_known_reg && (gap != '0)
                     && ((gap >= 32'(BW_WINDOW_ROUNDS))
                         || (!round_wrap && (32'(off) <= gap))
                         || (round_wrap && ((32'(off) <= ~filter_round_reg)
                                            || (32'(k) <= rounds_n))));
        end
    end

    assign slot_val = clr[cur_slot] ? 40'd0 : slots_reg[cur_slot];

    assign thr_base = base_reg;
    assign thr = {2'b00, thr_base} + {4'd0, thr_base[39:2]}
                 + {41'd0, (thr_base[1:0] != 2'b00)};
    assign stall_inc = (stall_reg < STALL_SAT) ? stall_reg + 4'd1 : stall_reg;
    assign fnow = !full_reg && started && rate_ok && !app_limited
                  && !((base_reg == '0) || ({2'b00, delivery_rate} >= thr))
                  && (stall_inc >= fbr_reg);

    assign pe = sknown_reg && (now_time > sstamp_reg)
                && ((now_time - sstamp_reg) > {24'd0, prt_int_reg});
    assign s_take = !sknown_reg || (rtt_sample < smin_reg) || pe;
    assign smin_n   = s_take ? rtt_sample : smin_reg;
    assign sstamp_n = s_take ? now_time : sstamp_reg;
    assign le = lknown_reg && (now_time > lstamp_reg)
                && ((now_time - lstamp_reg) > {24'd0, mrw_reg});
    assign l_take = !lknown_reg || (smin_n < lmin_reg) || le;

    always_comb
    begin
        max_tree = '0;
        for (int k = 0; k < BW_WINDOW_ROUNDS; k++)
        begin
            if (slots_reg[k] > max_tree)
            begin
                max_tree = slots_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fbr_reg     <= 4'd3;
            prt_int_reg <= 40'd5000000000;
            mrw_reg     <= 40'd10000000000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FULL_BW_ROUNDS: fbr_reg     <= cfg_data[3:0];
                CFG_PROBE_RTT_INT:  prt_int_reg <= cfg_data;
                CFG_MIN_RTT_WINDOW: mrw_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BW_WINDOW_ROUNDS; k++)
            begin
                slots_reg[k] <= '0;
            end
            bw_max_reg       <= '0;
            filter_round_reg <= '0;
            filter_known_reg <= 1'b0;
            rounds_reg       <= '0;
            rslot_reg        <= '0;
            fslot_reg        <= '0;
            mark_reg         <= '0;
            base_reg         <= '0;
            stall_reg        <= '0;
            full_reg         <= 1'b0;
            smin_reg         <= '0;
            sstamp_reg       <= '0;
            sknown_reg       <= 1'b0;
            lmin_reg         <= '0;
            lstamp_reg       <= '0;
            lknown_reg       <= 1'b0;
            last_time_reg    <= '0;
            last_known_reg   <= 1'b0;
            st_reg           <= 1'b0;
            started_reg      <= 1'b0;
            fnow_reg         <= 1'b0;
            pexp_reg         <= 1'b0;
            lexp_reg         <= 1'b0;
            bwres_reg        <= BW_RES_NONE;
        end
        else if (cmd.step)
        begin
            st_reg      <= reject;
            started_reg <= 1'b0;
            fnow_reg    <= 1'b0;
            pexp_reg    <= 1'b0;
            lexp_reg    <= 1'b0;
            bwres_reg   <= BW_RES_NONE;
            if (!reject)
            begin
                last_time_reg  <= now_time;
                last_known_reg <= 1'b1;
                started_reg    <= started;
                if (started)
                begin
                    mark_reg   <= delivered_total;
                    rounds_reg <= rounds_n;
                    rslot_reg  <= cur_slot;
                end
                if (rate_ok && !admit)
                begin
                    bwres_reg <= BW_RES_APPLIM;
                end
                if (admit)
                begin
                    bwres_reg        <= BW_RES_TAKEN;
                    filter_round_reg <= rounds_n;
                    fslot_reg        <= cur_slot;
                    filter_known_reg <= 1'b1;
                    for (int k = 0; k < BW_WINDOW_ROUNDS; k++)
                    begin
                        if ((SLOT_W'(k) == cur_slot) && (delivery_rate > slot_val))
                        begin
                            slots_reg[k] <= delivery_rate;
                        end
                        else if (clr[k])
                        begin
                            slots_reg[k] <= '0;
                        end
                    end
                end
                if (!full_reg && started && rate_ok && !app_limited)
                begin
                    if ((base_reg == '0) || ({2'b00, delivery_rate} >= thr))
                    begin
                        base_reg  <= delivery_rate;
                        stall_reg <= '0;
                    end
                    else
                    begin
                        stall_reg <= stall_inc;
                        fnow_reg  <= fnow;
                        if (fnow)
                        begin
                            full_reg <= 1'b1;
                        end
                    end
                end
                if (rtt_valid && (rtt_sample != '0))
                begin
                    pexp_reg   <= pe;
                    lexp_reg   <= le;
                    smin_reg   <= smin_n;
                    sstamp_reg <= sstamp_n;
                    sknown_reg <= 1'b1;
                    if (l_take)
                    begin
                        lmin_reg   <= smin_n;
                        lstamp_reg <= sstamp_n;
                    end
                    lknown_reg <= 1'b1;
                end
            end
        end
        else if (cmd.refresh)
        begin
            bw_max_reg <= max_tree;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status           <= st_reg;
            round_started    <= started_reg;
            round_number     <= rounds_reg;
            bw_sample_result <= bwres_reg;
            max_bandwidth    <= max_tree;
            bw_plateau_hit   <= fnow_reg;
            bw_plateau_seen  <= full_reg;
            min_rtt          <= lmin_reg;
            short_rtt_aged   <= pexp_reg;
            long_rtt_aged    <= lexp_reg;
        end
    end

endmodule

/* rtl/core/bbr_ack_path_model.sv */
//------------------------------------------------------------------------------
// bbr_ack_path_model
// BBR v1 ACK path: round counting, windowed max bandwidth, startup full-bw
// detection and two-level minimum RTT filter.
//
// Input channel in_valid/in_stall carries one ACK rate sample per request.
// Output channel out_valid/out_stall returns one result per request.
// Config channel cfg_valid/cfg_ready writes register cfg_index with cfg_data;
// write only while idle.
// An accepted request passes the update step, then a second step that takes
// the max over the slot registers and loads the result; in_stall is high
// during that step. A request is taken while an older result waits.
// Reset clears all filter state; config registers take their default values.
// When out_stall holds, the finished request stays in the second step and
// in_stall stays high until the output register frees.
//------------------------------------------------------------------------------
module bbr_ack_path_model (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] now_time,
    input  logic [47:0] delivered_total,
    input  logic [47:0] prior_delivered,
    input  logic [39:0] delivery_rate,
    input  logic        rate_valid,
    input  logic        app_limited,
    input  logic [39:0] rtt_sample,
    input  logic        rtt_valid,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic        round_started,
    output logic [31:0] round_number,
    output logic [1:0]  bw_sample_result,
    output logic [39:0] max_bandwidth,
    output logic        bw_plateau_hit,
    output logic        bw_plateau_seen,
    output logic [39:0] min_rtt,
    output logic        short_rtt_aged,
    output logic        long_rtt_aged,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data
);
    import bbr_pkg::*;

    bbr_cmd_t cmd;

    assign cfg_ready = 1'b1;

    bbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    bbr_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .now_time         (now_time),
        .delivered_total  (delivered_total),
        .prior_delivered  (prior_delivered),
        .delivery_rate    (delivery_rate),
        .rate_valid       (rate_valid),
        .app_limited      (app_limited),
        .rtt_sample       (rtt_sample),
        .rtt_valid        (rtt_valid),
        .status           (status),
        .round_started    (round_started),
        .round_number     (round_number),
        .bw_sample_result (bw_sample_result),
        .max_bandwidth    (max_bandwidth),
        .bw_plateau_hit   (bw_plateau_hit),
        .bw_plateau_seen  (bw_plateau_seen),
        .min_rtt          (min_rtt),
        .short_rtt_aged   (short_rtt_aged),
        .long_rtt_aged    (long_rtt_aged)
    );

endmodule
